// ===== rtl/core/assert_macros.svh =====
// Assertion macros used by the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== rtl/core/car_pkg.sv =====
// Shared types, constants and the cosine table function of the annealing rate block.
package car_pkg;

    localparam int RateW   = 32;
    localparam int BatchW  = 31;
    localparam int PeriodW = 16;
    localparam int PhaseW  = 16;
    localparam int FactorW = 17;
    localparam int FactorFracW = 16;
    localparam int CfgIdxW = 2;

    localparam int CosTableDepthDefault = 256;
    localparam int DivStepsPerStage = 4;

    localparam logic [RateW-1:0]   InitialRateReset = 32'd16777;
    localparam logic [RateW-1:0]   MinRateReset     = 32'd0;
    localparam logic [PeriodW-1:0] PeriodReset      = 16'd1000;

    localparam logic [FactorW-1:0] OneQ16  = 17'd65536;
    localparam logic [FactorW-1:0] HalfQ16 = 17'd32768;

    localparam logic [CfgIdxW-1:0] CfgInitialRate = 2'd0;
    localparam logic [CfgIdxW-1:0] CfgMinRate     = 2'd1;
    localparam logic [CfgIdxW-1:0] CfgPeriod      = 2'd2;

    localparam logic [63:0] PiQ30  = 64'd3373259426;
    localparam logic [63:0] OneQ30 = 64'd1 << 30;
    localparam logic [63:0] TaylorDiv [10] = '{
        64'd2, 64'd12, 64'd30, 64'd56, 64'd90,
        64'd132, 64'd182, 64'd240, 64'd306, 64'd380
    };

    // Control that travels alongside each item through the pipeline.
    typedef struct packed {
        logic valid;
        logic restore;
    } t_tag;

    // cos^2 of an angle in Q30 (0 to pi/2), rounded half up to Q16.
    // The cosine is an eleven-term Taylor series evaluated in Q30 with truncation.
    function automatic logic [FactorW-1:0] cos_sq_q16(input logic [63:0] angle);
        logic [63:0]        v_sq_angle;
        logic [63:0]        v_term;
        logic signed [63:0] v_sum;
        logic [63:0]        v_cos;
        logic [63:0]        v_sq;
        v_sq_angle = (angle * angle) >> 30;
        v_term = OneQ30;
        v_sum  = $signed(OneQ30);
        for (int n = 0; n < 10; n++) begin
            v_term = ((v_term * v_sq_angle) >> 30) / TaylorDiv[n[3:0]];
            if (n[0] == 1'b0) begin
                v_sum = v_sum - $signed(v_term);
            end else begin
                v_sum = v_sum + $signed(v_term);
            end
        end
        if (v_sum < 0) begin
            v_sum = '0;
        end
        if (v_sum > $signed(OneQ30)) begin
            v_sum = $signed(OneQ30);
        end
        v_cos = $unsigned(v_sum);
        v_sq  = v_cos * v_cos + (64'd1 << 43);
        return v_sq[60:44];
    endfunction

endpackage

// ===== rtl/core/car_divider.sv =====
// Pipelined restoring divider: batch modulo period, then the Q0.16 phase fraction.
module car_divider (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_en,
    input  car_pkg::t_tag            i_tag,
    input  logic [car_pkg::BatchW-1:0]  i_batch,
    input  logic [car_pkg::PeriodW-1:0] i_period,
    output car_pkg::t_tag            o_tag,
    output logic [car_pkg::PhaseW-1:0]  o_phase
);
    import car_pkg::*;

    localparam int ModStages = (BatchW + DivStepsPerStage - 1) / DivStepsPerStage;
    localparam int PhStages  = (PhaseW + DivStepsPerStage - 1) / DivStepsPerStage;

    // One shift-compare-subtract step; the top bit is the quotient bit.
    function automatic logic [PeriodW:0] div_step(
        input logic [PeriodW-1:0] rem,
        input logic               din,
        input logic [PeriodW-1:0] div
    );
        logic [PeriodW:0] v_t;
        v_t = {rem, din};
        if (v_t >= {1'b0, div}) begin
            return {1'b1, PeriodW'(v_t - {1'b0, div})};
        end
        return {1'b0, v_t[PeriodW-1:0]};
    endfunction

    t_tag                r_mod_tag [ModStages];
    logic [BatchW-1:0]   r_mod_bat [ModStages];
    logic [PeriodW-1:0]  r_mod_rem [ModStages];
    t_tag                r_ph_tag  [PhStages];
    logic [PeriodW-1:0]  r_ph_rem  [PhStages];
    logic [PhaseW-1:0]   r_ph_q    [PhStages];

    // Remainder stages: the batch number enters MSB first.
    for (genvar s = 0; s < ModStages; s++) begin : g_mod
        t_tag               w_tag_in;
        logic [BatchW-1:0]  w_bat_in;
        logic [PeriodW-1:0] w_rem_in;
        logic [BatchW-1:0]  n_bat;
        logic [PeriodW-1:0] n_rem;

        if (s == 0) begin : g_first
            assign w_tag_in = i_tag;
            assign w_bat_in = i_batch;
            assign w_rem_in = '0;
        end else begin : g_rest
            assign w_tag_in = r_mod_tag[s-1];
            assign w_bat_in = r_mod_bat[s-1];
            assign w_rem_in = r_mod_rem[s-1];
        end

        always_comb begin
            logic [PeriodW:0] v_step;
            v_step = '0;
            n_bat = w_bat_in;
            n_rem = w_rem_in;
            for (int j = 0; j < DivStepsPerStage; j++) begin
                if (s * DivStepsPerStage + j < BatchW) begin
                    v_step = div_step(n_rem, n_bat[BatchW-1], i_period);
                    n_rem  = v_step[PeriodW-1:0];
                    n_bat  = {n_bat[BatchW-2:0], 1'b0};
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_mod_tag[s].valid <= 1'b0;
            end else if (i_en) begin
                r_mod_tag[s] <= w_tag_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_mod_bat[s] <= n_bat;
                r_mod_rem[s] <= n_rem;
            end
        end
    end

    // Fraction stages: remainder * 2^16 / period, one quotient bit per step.
    for (genvar s = 0; s < PhStages; s++) begin : g_ph
        t_tag               w_tag_in;
        logic [PeriodW-1:0] w_rem_in;
        logic [PhaseW-1:0]  w_q_in;
        logic [PeriodW-1:0] n_rem;
        logic [PhaseW-1:0]  n_q;

        if (s == 0) begin : g_first
            assign w_tag_in = r_mod_tag[ModStages-1];
            assign w_rem_in = r_mod_rem[ModStages-1];
            assign w_q_in   = '0;
        end else begin : g_rest
            assign w_tag_in = r_ph_tag[s-1];
            assign w_rem_in = r_ph_rem[s-1];
            assign w_q_in   = r_ph_q[s-1];
        end

        always_comb begin
            logic [PeriodW:0] v_step;
            v_step = '0;
            n_rem = w_rem_in;
            n_q   = w_q_in;
            for (int j = 0; j < DivStepsPerStage; j++) begin
                if (s * DivStepsPerStage + j < PhaseW) begin
                    v_step = div_step(n_rem, 1'b0, i_period);
                    n_rem  = v_step[PeriodW-1:0];
                    n_q    = {n_q[PhaseW-2:0], v_step[PeriodW]};
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_ph_tag[s].valid <= 1'b0;
            end else if (i_en) begin
                r_ph_tag[s] <= w_tag_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_ph_rem[s] <= n_rem;
                r_ph_q[s]   <= n_q;
            end
        end
    end

    // A zero period means phase zero, which selects the full initial rate.
    assign o_tag   = r_ph_tag[PhStages-1];
    assign o_phase = (i_period == '0) ? '0 : r_ph_q[PhStages-1];

endmodule

// ===== rtl/core/car_cos_rom.sv =====
// Phase to table index, then a registered read of the cosine factor ROM.
module car_cos_rom #(
    parameter int COS_TABLE_DEPTH = car_pkg::CosTableDepthDefault
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  car_pkg::t_tag               i_tag,
    input  logic [car_pkg::PhaseW-1:0]  i_phase,
    output car_pkg::t_tag               o_tag,
    output logic [car_pkg::FactorW-1:0] o_factor
);
    import car_pkg::*;

    localparam int IdxW  = $clog2(COS_TABLE_DEPTH + 1);
    localparam int ProdW = PhaseW + IdxW + 1;

    logic [FactorW-1:0] w_cos_rom [COS_TABLE_DEPTH+1];

    // Entry k holds 0.5*(1+cos(pi*k/depth)) in Q1.16.
    for (genvar k = 0; k <= COS_TABLE_DEPTH; k++) begin : g_rom
        localparam logic [63:0] AngleQ30 =
            (PiQ30 * 64'(k)) / (64'd2 * 64'(COS_TABLE_DEPTH));
        assign w_cos_rom[k] = cos_sq_q16(AngleQ30);
    end

    logic [ProdW-1:0] w_scaled;
    t_tag             r_idx_tag;
    logic [IdxW-1:0]  r_idx;
    t_tag             r_f_tag;
    logic [FactorW-1:0] r_factor;

    // Rounded index; never exceeds the depth since phase stays below one.
    assign w_scaled = ProdW'(i_phase) * ProdW'(COS_TABLE_DEPTH) + ProdW'(HalfQ16);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx_tag.valid <= 1'b0;
            r_f_tag.valid   <= 1'b0;
        end else if (i_en) begin
            r_idx_tag <= i_tag;
            r_f_tag   <= r_idx_tag;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_idx    <= w_scaled[PhaseW +: IdxW];
            r_factor <= w_cos_rom[r_idx];
        end
    end

    assign o_tag    = r_f_tag;
    assign o_factor = r_factor;

endmodule

// ===== rtl/core/car_blend.sv =====
// Blend of minimum and initial rates by the cosine factor, with rounding and saturation.
module car_blend (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  car_pkg::t_tag               i_tag,
    input  logic [car_pkg::FactorW-1:0] i_factor,
    input  logic [car_pkg::RateW-1:0]   i_initial_rate,
    input  logic [car_pkg::RateW-1:0]   i_min_rate,
    output car_pkg::t_tag               o_tag,
    output logic [car_pkg::RateW-1:0]   o_rate
);
    import car_pkg::*;

    localparam int ProdW  = RateW + FactorW;
    localparam int SumW   = ProdW + 1;
    localparam int ShiftW = SumW - FactorFracW;

    logic [FactorW-1:0] w_inv;
    t_tag               r_p_tag;
    logic [ProdW-1:0]   r_p_min;
    logic [ProdW-1:0]   r_p_init;
    t_tag               r_s_tag;
    logic [SumW-1:0]    r_total;
    logic [ShiftW-1:0]  w_shift;
    logic [RateW-1:0]   w_sat;

    assign w_inv = OneQ16 - i_factor;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_tag.valid <= 1'b0;
            r_s_tag.valid <= 1'b0;
        end else if (i_en) begin
            r_p_tag <= i_tag;
            r_s_tag <= r_p_tag;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p_min  <= ProdW'(i_min_rate) * ProdW'(w_inv);
            r_p_init <= ProdW'(i_initial_rate) * ProdW'(i_factor);
            r_total  <= SumW'(r_p_min) + SumW'(r_p_init) + SumW'(HalfQ16);
        end
    end

    assign w_shift = r_total[SumW-1:FactorFracW];
    assign w_sat   = (|w_shift[ShiftW-1:RateW]) ? '1 : w_shift[RateW-1:0];

    assign o_tag  = r_s_tag;
    assign o_rate = r_s_tag.restore ? i_initial_rate : w_sat;

endmodule

// ===== rtl/core/cosine_annealing_rate_top.sv =====
// Top level of the cosine-annealed learning rate block.
//
//  Channel  Dir  Handshake                   Payload
//  input    in   i_valid / o_stall           i_req_type, i_batch_num
//  output   out  o_valid / i_stall           o_learning_rate
//  config   in   i_cfg_valid / o_cfg_ready   i_cfg_index, i_cfg_data
//
// A request can enter every cycle while o_stall is low. Sixteen pipeline stages lie between
// the input and the output register: the 31-step remainder and 16-step fraction division
// at four steps per stage (12), then the index and ROM read (2) and the multiply and sum
// (2). Reset is synchronous and active low; it loads the register reset values and empties
// the pipeline. An output register with a one-entry skid parts the two sides, so o_stall
// is a register and rises only after a result has been held back by i_stall.
module cosine_annealing_rate_top #(
    parameter int COS_TABLE_DEPTH = car_pkg::CosTableDepthDefault
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic                        i_req_type,
    input  logic [car_pkg::BatchW-1:0]  i_batch_num,
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic [car_pkg::RateW-1:0]   o_learning_rate,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [car_pkg::CfgIdxW-1:0] i_cfg_index,
    input  logic [car_pkg::RateW-1:0]   i_cfg_data
);
    import car_pkg::*;

    // Configuration registers. The user must change them only while no request is in flight; the
    // block does not enforce this, and the pipeline reads them directly.
    logic [RateW-1:0]   r_initial_rate;
    logic [RateW-1:0]   r_min_rate;
    logic [PeriodW-1:0] r_period;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_initial_rate <= InitialRateReset;
            r_min_rate     <= MinRateReset;
            r_period       <= PeriodReset;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CfgInitialRate: r_initial_rate <= i_cfg_data;
                CfgMinRate:     r_min_rate     <= i_cfg_data;
                CfgPeriod:      r_period       <= i_cfg_data[PeriodW-1:0];
                default: begin
                end
            endcase
        end
    end

    // The whole pipeline moves together whenever the skid entry is free. An item in the
    // last stage is consumed exactly on those cycles, into the output register or skid.
    logic r_out_valid;
    logic r_skid_valid;
    logic [RateW-1:0] r_out_rate;
    logic [RateW-1:0] r_skid_rate;
    logic w_en;
    logic w_take;

    assign w_en   = !r_skid_valid;
    assign w_take = r_out_valid && !i_stall;

    t_tag               w_in_tag;
    t_tag               w_div_tag;
    logic [PhaseW-1:0]  w_phase;
    t_tag               w_rom_tag;
    logic [FactorW-1:0] w_factor;
    t_tag               w_blend_tag;
    logic [RateW-1:0]   w_rate;

    assign w_in_tag = '{valid: i_valid, restore: i_req_type};

    car_divider u_divider (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (w_en),
        .i_tag    (w_in_tag),
        .i_batch  (i_batch_num),
        .i_period (r_period),
        .o_tag    (w_div_tag),
        .o_phase  (w_phase)
    );

    car_cos_rom #(
        .COS_TABLE_DEPTH (COS_TABLE_DEPTH)
    ) u_cos_rom (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (w_en),
        .i_tag    (w_div_tag),
        .i_phase  (w_phase),
        .o_tag    (w_rom_tag),
        .o_factor (w_factor)
    );

    // A restore request carries through the pipeline and picks the initial rate at
    // the end; the held rate is always the value just returned.
    car_blend u_blend (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_en           (w_en),
        .i_tag          (w_rom_tag),
        .i_factor       (w_factor),
        .i_initial_rate (r_initial_rate),
        .i_min_rate     (r_min_rate),
        .o_tag          (w_blend_tag),
        .o_rate         (w_rate)
    );

    // Output register and skid entry. When the skid holds a result the pipeline is
    // frozen, so no new result arrives on that cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (w_take) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end
        end else if (!r_out_valid || w_take) begin
            r_out_valid <= w_blend_tag.valid;
        end else if (w_blend_tag.valid) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (w_take) begin
                r_out_rate <= r_skid_rate;
            end
        end else if (!r_out_valid || w_take) begin
            r_out_rate <= w_rate;
        end else begin
            r_skid_rate <= w_rate;
        end
    end

    assign o_stall         = r_skid_valid;
    assign o_valid         = r_out_valid;
    assign o_learning_rate = r_out_rate;

endmodule

// ===== rtl/core/car_checker.sv =====
// Port-level checks of the output register and skid of the annealing rate block.
`include "assert_macros.svh"

module car_checker (
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      i_stall,
    input logic                      o_valid,
    input logic                      o_stall,
    input logic [car_pkg::RateW-1:0] o_learning_rate
);

    // A stalled result stays and keeps its value.
    `ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && i_stall, o_valid && $stable(o_learning_rate))

    // The skid only fills behind a waiting output register.
    `ASSERT_IMPL(a_skid_behind_out, i_clk, i_rst_n, o_stall, o_valid)

    // The skid fills only after a result was held back.
    `ASSERT_IMPL(a_skid_cause, i_clk, i_rst_n, o_stall, $past(o_valid && i_stall))

    // A taken result is replaced by the skid entry, which frees the input.
    `ASSERT_NEXT(a_skid_drain, i_clk, i_rst_n, o_stall && !i_stall, o_valid && !o_stall)

endmodule

bind cosine_annealing_rate_top car_checker u_car_checker (.*);

// ===== verif/tb.sv =====
// Self-checking testbench for the cosine-annealed learning rate block, with a local rate model.
module tb;
    import car_pkg::*;

    // The block is built with its default table depth, so the model uses the same depth.
    localparam int                 CosDepth     = CosTableDepthDefault;
    localparam logic [63:0]        PiFixed30    = 64'd3373259426;
    localparam logic               ReqUpdate    = 1'b0;
    localparam logic               ReqRestore   = 1'b1;
    localparam logic [CfgIdxW-1:0] CfgSpare     = 2'd3;
    localparam int                 RandomItems  = 1800;
    localparam int                 RandomPhases = 8;
    localparam int                 MaxIdle      = 14;
    localparam int                 DrainCycles  = 40;
    localparam int                 CycleLimit   = 400000;

    // One pending request for the driver, with the number of idle cycles that
    // the sender spends before presenting it.
    typedef struct {
        logic              req_type;
        logic [BatchW-1:0] batch;
        int unsigned       gap;
    } t_lr_request;

    logic               i_clk        = 1'b0;
    logic               i_rst_n      = 1'b0;
    logic               i_valid      = 1'b0;
    logic               o_stall;
    logic               i_req_type   = ReqUpdate;
    logic [BatchW-1:0]  i_batch_num  = '0;
    logic               o_valid;
    logic               i_stall      = 1'b0;
    logic [RateW-1:0]   o_learning_rate;
    logic               i_cfg_valid  = 1'b0;
    logic               o_cfg_ready;
    logic [CfgIdxW-1:0] i_cfg_index  = CfgInitialRate;
    logic [RateW-1:0]   i_cfg_data   = '0;

    // Local copies of the configuration registers and of the held rate. They
    // follow the register writes and the accepted requests seen on the ports.
    logic [RateW-1:0]   cfg_initial     = InitialRateReset;
    logic [RateW-1:0]   cfg_min         = MinRateReset;
    logic [PeriodW-1:0] cfg_period      = PeriodReset;
    logic [RateW-1:0]   held_rate_model = InitialRateReset;

    // Annealing factor 0.5*(1+cos(pi*k/depth)) in Q1.16, filled at time zero.
    logic [FactorW-1:0] half_cos_sq [0:CosDepth];

    t_lr_request      pending_reqs [$];
    logic [RateW-1:0] rate_due [$];
    t_lr_request      drv_item;

    int          queued_count = 0;
    int          taken_count  = 0;
    int          error_count  = 0;
    int          cycle_count  = 0;
    int unsigned gap_count    = 0;
    int unsigned stall_left   = 0;
    int unsigned tx_idle_max  = MaxIdle;
    int unsigned rx_idle_max  = MaxIdle;

    // Handshake flags captured at the rising edge and used by the drivers at
    // the following falling edge.
    logic req_taken  = 1'b0;
    logic rate_taken = 1'b0;

    cosine_annealing_rate_top uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_req_type      (i_req_type),
        .i_batch_num     (i_batch_num),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_learning_rate (o_learning_rate),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    always #1 i_clk = ~i_clk;

    // Works out the held rate after one request and updates the local copy.
    // An update folds the batch into the cycle, turns the position into a Q0.16
    // phase, rounds that to a table slot and blends min and initial with the
    // factor found there, rounding half up and saturating to 32 bits. A period
    // of zero pins the phase at the start of the cycle.
    function automatic logic [RateW-1:0] next_held_rate(input logic req,
                                                        input logic [BatchW-1:0] batch);
        logic [63:0] phase;
        logic [63:0] slot;
        logic [63:0] factor;
        logic [63:0] blend;
        if (req == ReqRestore) begin
            held_rate_model = cfg_initial;
            return held_rate_model;
        end
        phase = '0;
        if (cfg_period != '0) begin
            phase = ((64'(batch) % 64'(cfg_period)) << 16) / 64'(cfg_period);
        end
        slot = (phase * 64'(CosDepth) + 64'd32768) >> 16;
        if (slot > 64'(CosDepth)) begin
            slot = 64'(CosDepth);
        end
        factor = 64'(half_cos_sq[slot]);
        if (factor > 64'd65536) begin
            factor = 64'd65536;
        end
        blend = 64'(cfg_min) * (64'd65536 - factor) + 64'(cfg_initial) * factor;
        blend = (blend + 64'd32768) >> 16;
        held_rate_model = (blend > 64'hFFFF_FFFF) ? '1 : blend[RateW-1:0];
        return held_rate_model;
    endfunction

    // Driver of the request channel. A presented request is held until it is
    // taken; after that the next one waits out its own gap before it shows up.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (!i_valid || req_taken) begin
            if (pending_reqs.size() != 0 && gap_count >= pending_reqs[0].gap) begin
                drv_item = pending_reqs.pop_front();
                i_valid     <= 1'b1;
                i_req_type  <= drv_item.req_type;
                i_batch_num <= drv_item.batch;
                gap_count = 0;
            end else begin
                i_valid <= 1'b0;
                if (pending_reqs.size() != 0) begin
                    gap_count++;
                end
            end
        end
    end

    // Receiver side: after each taken result a fresh stall length is drawn, so
    // stalls land both on waiting results and on empty cycles.
    always @(negedge i_clk) begin
        if (rate_taken) begin
            stall_left = $urandom_range(0, rx_idle_max);
        end
        if (stall_left != 0) begin
            i_stall <= 1'b1;
            stall_left--;
        end else begin
            i_stall <= 1'b0;
        end
    end

    // Monitor: follows register writes, predicts a rate for every accepted
    // request and checks every accepted result against the oldest prediction.
    always @(posedge i_clk) begin
        logic [RateW-1:0] due;
        req_taken  <= i_rst_n && i_valid && !o_stall;
        rate_taken <= i_rst_n && o_valid && !i_stall;
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CfgInitialRate: begin
                        cfg_initial = i_cfg_data;
                    end
                    CfgMinRate: begin
                        cfg_min = i_cfg_data;
                    end
                    CfgPeriod: begin
                        cfg_period = i_cfg_data[PeriodW-1:0];
                    end
                    default: begin
                    end
                endcase
            end
            if (i_valid && !o_stall) begin
                rate_due.push_back(next_held_rate(i_req_type, i_batch_num));
                taken_count++;
            end
            if (o_valid && !i_stall) begin
                if (rate_due.size() == 0) begin
                    $error("learning_rate: no request outstanding, actual %0h",
                           o_learning_rate);
                    error_count++;
                end else begin
                    due = rate_due.pop_front();
                    if (o_learning_rate !== due) begin
                        $error("learning_rate: expected %0h, actual %0h", due,
                               o_learning_rate);
                        error_count++;
                    end
                end
            end
        end
    end

    // Watchdog on the whole run.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CycleLimit) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Adds one request to the driver's queue, with a gap drawn from the
    // sender's current idle range.
    task automatic queue_request(input logic req, input logic [BatchW-1:0] batch);
        t_lr_request item;
        item.req_type = req;
        item.batch    = batch;
        item.gap      = $urandom_range(0, tx_idle_max);
        pending_reqs.push_back(item);
        queued_count++;
    endtask

    // Presents one register write and waits until the block takes it. The
    // valid stays high so that back-to-back writes follow without a gap; the
    // caller lowers it after the last write.
    task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [RateW-1:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
    endtask

    // Rewrites all three registers, then ends the write burst.
    task automatic load_schedule(input logic [RateW-1:0] init_rate,
                                 input logic [RateW-1:0] floor_rate,
                                 input logic [PeriodW-1:0] cycle_len);
        write_reg(CfgInitialRate, init_rate);
        write_reg(CfgMinRate, floor_rate);
        write_reg(CfgPeriod, {{(RateW-PeriodW){1'b0}}, cycle_len});
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Holds the stimulus back until every queued request has been taken and
    // its rate has come out.
    task automatic wait_idle();
        do @(negedge i_clk); while (taken_count != queued_count || rate_due.size() != 0);
    endtask

    initial begin
        logic [63:0]        angle;
        logic [63:0]        angle_sq;
        logic [63:0]        term;
        logic signed [63:0] series;
        logic [63:0]        cos_val;
        logic [63:0]        wide;
        logic [RateW-1:0]   init_val;
        logic [RateW-1:0]   min_val;
        logic [PeriodW-1:0] per_val;
        logic [BatchW-1:0]  batch;
        logic               req;
        int                 per_phase;

        // The factor table: the angle pi*k/(2*depth) in Q30, an eleven-term Taylor
        // series for its cosine with truncation, clamped to [0, 1], then the
        // square rounded half up to Q16.
        for (int k = 0; k <= CosDepth; k++) begin
            angle    = (PiFixed30 * 64'(k)) / (64'd2 * 64'(CosDepth));
            angle_sq = (angle * angle) >> 30;
            term     = 64'd1 << 30;
            series   = $signed(64'd1 << 30);
            for (int n = 1; n <= 10; n++) begin
                term = ((term * angle_sq) >> 30) / 64'((2 * n - 1) * (2 * n));
                if (n % 2 == 1) begin
                    series = series - $signed(term);
                end else begin
                    series = series + $signed(term);
                end
            end
            if (series < 0) begin
                series = '0;
            end
            if (series > $signed(64'd1 << 30)) begin
                series = $signed(64'd1 << 30);
            end
            cos_val = $unsigned(series);
            half_cos_sq[k] = FactorW'((cos_val * cos_val + (64'd1 << 43)) >> 44);
        end

        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part, first with the reset values of the registers: a
        // restore whose batch number must be ignored, both ends of a cycle,
        // its midpoint, the wrap into the next cycle, and the batch extremes.
        queue_request(ReqRestore, '1);
        queue_request(ReqUpdate, 31'd0);
        queue_request(ReqUpdate, 31'd250);
        queue_request(ReqUpdate, 31'd500);
        queue_request(ReqUpdate, 31'd999);
        queue_request(ReqUpdate, 31'd1000);
        queue_request(ReqUpdate, 31'd1001);
        queue_request(ReqUpdate, 31'h7FFF_FFFF);
        queue_request(ReqUpdate, 31'h2AAA_AAAA);
        queue_request(ReqUpdate, 31'h5555_5555);
        wait_idle();

        // A period of one keeps the phase at zero, so the rate is the full
        // initial rate, here the largest one.
        load_schedule('1, '0, 16'd1);
        queue_request(ReqUpdate, 31'd12345);
        queue_request(ReqUpdate, 31'h7FFF_FFFF);
        wait_idle();

        // The spare register index must be ignored. Then the initial rate lies
        // below the minimum, so the rate climbs over the longest cycle.
        write_reg(CfgSpare, $urandom());
        load_schedule('0, '1, 16'hFFFF);
        queue_request(ReqUpdate, 31'd0);
        queue_request(ReqUpdate, 31'd32767);
        queue_request(ReqUpdate, 31'd65534);
        queue_request(ReqUpdate, 31'd65535);
        wait_idle();

        // A period of zero takes the phase as zero.
        load_schedule('0, '1, 16'd0);
        queue_request(ReqUpdate, 31'h7FFF_FFFF);
        queue_request(ReqRestore, 31'd0);
        wait_idle();

        // Equal rates at the top of the range: the blend must stay flat.
        load_schedule('1, '1, 16'd7);
        queue_request(ReqUpdate, 31'd3);
        wait_idle();

        // Random part. Each phase takes a new register setting and its own
        // idle pattern; the first phase runs with no idling on either side.
        per_phase = RandomItems / RandomPhases;
        for (int ph = 0; ph < RandomPhases; ph++) begin
            case (ph % 4)
                0: begin
                    tx_idle_max = (ph == 0) ? 0 : MaxIdle;
                    rx_idle_max = (ph == 0) ? 0 : MaxIdle;
                end
                1: begin
                    tx_idle_max = 0;
                    rx_idle_max = MaxIdle;
                end
                2: begin
                    tx_idle_max = MaxIdle;
                    rx_idle_max = 0;
                end
                default: begin
                    tx_idle_max = MaxIdle;
                    rx_idle_max = MaxIdle;
                end
            endcase

            case ($urandom_range(0, 3))
                0: init_val = '1;
                1: init_val = '0;
                default: init_val = $urandom();
            endcase
            case ($urandom_range(0, 3))
                0: min_val = '1;
                1: min_val = '0;
                default: min_val = $urandom();
            endcase
            case ($urandom_range(0, 7))
                0: per_val = 16'hFFFF;
                1: per_val = 16'd1;
                2: per_val = 16'd0;
                3, 4, 5: per_val = PeriodW'($urandom_range(1, 300));
                default: per_val = PeriodW'($urandom_range(1, 65535));
            endcase
            if ($urandom_range(0, 3) == 0) begin
                write_reg(CfgSpare, $urandom());
            end
            load_schedule(init_val, min_val, per_val);

            for (int i = 0; i < per_phase; i++) begin
                // Most batches fall near cycle boundaries or within the first
                // few cycles, so that every part of the curve gets hit; the
                // rest are spread over the whole 31-bit range.
                case ($urandom_range(0, 3))
                    0: begin
                        wide = 64'($urandom());
                    end
                    1: begin
                        wide = 64'($urandom_range(0, 2 * per_val + 2));
                    end
                    2: begin
                        wide = 64'($urandom_range(0, 30000)) * 64'(per_val);
                        case ($urandom_range(0, 2))
                            0: wide = wide + 64'd1;
                            1: wide = wide + 64'(per_val) - 64'd1;
                            default: wide = wide + 64'($urandom_range(0, per_val));
                        endcase
                    end
                    default: begin
                        wide = 64'($urandom_range(0, 4095));
                    end
                endcase
                batch = wide[BatchW-1:0];
                req = ($urandom_range(0, 7) == 0) ? ReqRestore : ReqUpdate;
                queue_request(req, batch);
                // Once in the run the sender stops halfway and lets the
                // pipeline empty completely before it resumes.
                if (ph == 3 && i == per_phase / 2) begin
                    wait_idle();
                end
            end
            wait_idle();
        end

        repeat (DrainCycles) @(posedge i_clk);
        if (error_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
